/* rtl/ringtone_note_parser_macros.svh */
// Assertion macros shared by the ringtone note parser modules.
`ifndef RINGTONE_NOTE_PARSER_MACROS_SVH
`define RINGTONE_NOTE_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RTNP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RTNP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rtnp_pkg.sv */
// Types, constants and tables of the ringtone note parser.
package rtnp_pkg;

    localparam int NOTE_CHARS_DEF = 6;

    localparam int CH_W       = 8;
    localparam int STATUS_W   = 2;
    localparam int TONE_W     = 4;
    localparam int OCT_W      = 4;
    localparam int DUR_W      = 8;
    localparam int TEMPO_W    = 10;
    localparam int IV_W       = 19;
    localparam int FREQ_W     = 14;
    localparam int TB_W       = 12;
    localparam int FSH_W      = 21;
    localparam int DIV_W      = 18;
    localparam int DVSR_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_DEF_DUR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_OCT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMPO   = 2'd2;

    localparam logic [DUR_W-1:0]   DEF_DUR_RST = 8'd4;
    localparam logic [OCT_W-1:0]   DEF_OCT_RST = 4'd6;
    localparam logic [TEMPO_W-1:0] TEMPO_RST   = 10'd63;

    localparam logic [DUR_W-1:0]  DUR_MAX    = 8'd255;
    localparam logic [OCT_W-1:0]  OCT_MAX    = 4'd9;
    localparam logic [TONE_W-1:0] TONE_PAUSE = 4'd12;
    localparam logic [DIV_W-1:0]  MS_PER_MIN = 18'd60000;

    localparam logic [CH_W-1:0] CHR_COMMA = 8'h2C;
    localparam logic [CH_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CHR_HASH  = 8'h23;
    localparam logic [CH_W-1:0] CHR_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CHR_0     = 8'h30;
    localparam logic [CH_W-1:0] CHR_9     = 8'h39;
    localparam logic [CH_W-1:0] CHR_A     = 8'h61;
    localparam logic [CH_W-1:0] CHR_B     = 8'h62;
    localparam logic [CH_W-1:0] CHR_C     = 8'h63;
    localparam logic [CH_W-1:0] CHR_D     = 8'h64;
    localparam logic [CH_W-1:0] CHR_E     = 8'h65;
    localparam logic [CH_W-1:0] CHR_F     = 8'h66;
    localparam logic [CH_W-1:0] CHR_G     = 8'h67;
    localparam logic [CH_W-1:0] CHR_P     = 8'h70;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_EMPTY,
        ST_ZERO_DUR,
        ST_ENDED
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUR,
        S_TONE,
        S_SHARP,
        S_DOT,
        S_OCT,
        S_DIV1,
        S_DIV2,
        S_FIN
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [TONE_W-1:0] tone;
        logic              sharpable;
    } letter_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // Base pitch in 1/256 Hz, lowest octave, before the octave shift.
    function automatic logic [TB_W-1:0] tone_base(input logic [TONE_W-1:0] t);
        logic [TB_W-1:0] r;
        case (t)
            4'd0:    r = 12'd2093;
            4'd1:    r = 12'd2217;
            4'd2:    r = 12'd2349;
            4'd3:    r = 12'd2489;
            4'd4:    r = 12'd2637;
            4'd5:    r = 12'd2794;
            4'd6:    r = 12'd2960;
            4'd7:    r = 12'd3136;
            4'd8:    r = 12'd3322;
            4'd9:    r = 12'd3520;
            4'd10:   r = 12'd3729;
            4'd11:   r = 12'd3951;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic letter_t decode_letter(input logic [CH_W-1:0] c);
        letter_t r;
        r = '0;
        case (c)
            CHR_C:   r = '{valid: 1'b1, tone: 4'd0,  sharpable: 1'b1};
            CHR_D:   r = '{valid: 1'b1, tone: 4'd2,  sharpable: 1'b1};
            CHR_E:   r = '{valid: 1'b1, tone: 4'd4,  sharpable: 1'b0};
            CHR_F:   r = '{valid: 1'b1, tone: 4'd5,  sharpable: 1'b1};
            CHR_G:   r = '{valid: 1'b1, tone: 4'd7,  sharpable: 1'b1};
            CHR_A:   r = '{valid: 1'b1, tone: 4'd9,  sharpable: 1'b1};
            CHR_B:   r = '{valid: 1'b1, tone: 4'd11, sharpable: 1'b0};
            CHR_P:   r = '{valid: 1'b1, tone: TONE_PAUSE, sharpable: 1'b0};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/rtnp_ifs.sv */
// Valid/ready channel interfaces for characters in and notes out.
interface rtnp_char_if;
    logic                      valid;
    logic                      ready;
    logic [rtnp_pkg::CH_W-1:0] ch;
    logic                      end_of_melody;

    modport source (output valid, output ch, output end_of_melody, input ready);
    modport sink (input valid, input ch, input end_of_melody, output ready);
endinterface

interface rtnp_note_if;
    logic                          valid;
    logic                          ready;
    logic [rtnp_pkg::STATUS_W-1:0] status;
    logic [rtnp_pkg::TONE_W-1:0]   tone_index;
    logic [rtnp_pkg::OCT_W-1:0]    octave;
    logic [rtnp_pkg::DUR_W-1:0]    duration_div;
    logic                          dotted;
    logic [rtnp_pkg::IV_W-1:0]     interval_ms;
    logic [rtnp_pkg::FREQ_W-1:0]   frequency_hz;

    modport source (
        output valid, output status, output tone_index, output octave,
        output duration_div, output dotted, output interval_ms, output frequency_hz,
        input ready
    );
    modport sink (
        input valid, input status, input tone_index, input octave,
        input duration_div, input dotted, input interval_ms, input frequency_hz,
        output ready
    );
endinterface

/* rtl/rtnp_divider.sv */
// Restoring divider that produces one quotient bit per cycle.
`include "ringtone_note_parser_macros.svh"

module rtnp_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  rtnp_pkg::div_req_t req,
    output rtnp_pkg::div_rsp_t rsp
);
    import rtnp_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DVSR_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DVSR_W-1:0] dvs_reg, dvs_next;

    logic [DVSR_W:0]   rem_sh;
    logic [DVSR_W:0]   diff;
    logic              fits;

    always_comb
    begin
        // The dividend shifts out of the top of quo_reg as quotient bits enter below.
        rem_sh = {rem_reg, quo_reg[DIV_W-1]};
        diff   = rem_sh - {1'b0, dvs_reg};
        fits   = rem_sh >= {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `RTNP_ASSERT_IMP(a_start_idle, req.start, !busy_reg, "divider started while busy")
    `RTNP_ASSERT_NXT(a_done_pulse, done_reg, !done_reg, "divider done held longer than a cycle")
    `RTNP_ASSERT_IMP(a_rem_below, busy_reg && dvs_reg != '0, rem_reg < dvs_reg,
        "partial remainder not below divisor")

endmodule

/* rtl/ringtone_note_parser.sv */
// Ringtone note parser: buffers note characters and emits one parsed note per closing comma or end_of_melody.
//
// Characters are taken one word per cycle while the parser is idle. A comma, or a
// character marked end_of_melody, starts parsing: the sequencer walks the buffered
// characters in order (duration digits, tone letter, sharp, dot, octave digits), then
// the shared radix-2 divider computes 60000/tempo and then the whole-note time divided
// by the duration. A note with zero duration, an empty note and an end without a note
// skip the divider. The finished note sits in an output register, so the parser takes
// further characters while it waits to be read.
`include "ringtone_note_parser_macros.svh"

module ringtone_note_parser #(
    parameter int NOTE_CHARS = rtnp_pkg::NOTE_CHARS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rtnp_char_if.sink                         char_in,
    rtnp_note_if.source                       note_out,
    input  logic                              wr_en,
    input  logic [rtnp_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [rtnp_pkg::CFG_DATA_W-1:0]   wr_data
);
    import rtnp_pkg::*;

    localparam int CW    = $clog2(NOTE_CHARS + 1);
    localparam int IW    = $clog2(NOTE_CHARS);
    localparam int ACC_W = DUR_W + 4;

    // Configuration
    logic [DUR_W-1:0]   def_dur_reg;
    logic [OCT_W-1:0]   def_oct_reg;
    logic [TEMPO_W-1:0] tempo_reg;

    // Character buffer and control
    logic [CH_W-1:0]    note_chars_reg [NOTE_CHARS];
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      cnt_after;
    logic               buf_we;
    state_t             state_reg, state_next;
    logic [TONE_W-1:0]  last_tone_reg, last_tone_next;

    // Parse working registers
    logic [CW-1:0]      pos_reg, pos_next;
    logic [DUR_W-1:0]   acc_reg, acc_next;
    logic               found_reg, found_next;
    logic [DUR_W-1:0]   dur_reg, dur_next;
    logic [TONE_W-1:0]  tone_reg, tone_next;
    logic               sharp_ok_reg, sharp_ok_next;
    logic               dotted_reg, dotted_next;
    logic [OCT_W-1:0]   oct_reg, oct_next;
    logic [IV_W-1:0]    iv_reg, iv_next;
    logic [FREQ_W-1:0]  freq_reg, freq_next;
    status_t            status_reg, status_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic               load_out;
    status_t            out_status_reg;
    logic [TONE_W-1:0]  out_tone_reg;
    logic [OCT_W-1:0]   out_oct_reg;
    logic [DUR_W-1:0]   out_dur_reg;
    logic               out_dotted_reg;
    logic [IV_W-1:0]    out_iv_reg;
    logic [FREQ_W-1:0]  out_freq_reg;

    // Combinational helpers
    logic [CH_W-1:0]    cur_ch;
    logic               have_ch;
    logic               is_digit;
    logic [ACC_W-1:0]   acc_x10;
    logic [ACC_W-1:0]   acc_limit;
    logic [ACC_W-1:0]   acc_sat;
    letter_t            letter;
    logic [OCT_W-1:0]   oct_final;
    logic [FSH_W-1:0]   freq_shifted;
    logic [FSH_W-1:0]   freq_rounded;
    logic [TEMPO_W-1:0] tempo_eff;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    rtnp_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        cur_ch   = note_chars_reg[pos_reg[IW-1:0]];
        have_ch  = pos_reg < cnt_reg;
        is_digit = cur_ch inside {[CHR_0:CHR_9]};

        // Shared decimal accumulator: acc*10 + digit, clamped to the field limit.
        acc_x10 = ({{(ACC_W-DUR_W){1'b0}}, acc_reg} << 3)
                + ({{(ACC_W-DUR_W){1'b0}}, acc_reg} << 1)
                + {{(ACC_W-4){1'b0}}, cur_ch[3:0]};
        acc_limit = (state_reg == S_DUR) ? {{(ACC_W-DUR_W){1'b0}}, DUR_MAX}
                                         : {{(ACC_W-OCT_W){1'b0}}, OCT_MAX};
        acc_sat = (acc_x10 > acc_limit) ? acc_limit : acc_x10;

        letter = decode_letter(cur_ch);

        if (found_reg)
            oct_final = acc_reg[OCT_W-1:0];
        else if (def_oct_reg > OCT_MAX)
            oct_final = OCT_MAX;
        else
            oct_final = def_oct_reg;

        freq_shifted = {{(FSH_W-TB_W){1'b0}}, tone_base(tone_reg)} << oct_final;
        freq_rounded = freq_shifted + FSH_W'(128);

        tempo_eff = (tempo_reg == '0) ? TEMPO_W'(1) : tempo_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cnt_after      = cnt_reg;
        buf_we         = 1'b0;
        last_tone_next = last_tone_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        found_next     = found_reg;
        dur_next       = dur_reg;
        tone_next      = tone_reg;
        sharp_ok_next  = sharp_ok_reg;
        dotted_next    = dotted_reg;
        oct_next       = oct_reg;
        iv_next        = iv_reg;
        freq_next      = freq_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !note_out.ready;
        load_out       = 1'b0;
        div_req        = '0;
        char_in.ready  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                char_in.ready = 1'b1;
                if (char_in.valid)
                begin
                    if (char_in.ch != CHR_COMMA
                        && !(cnt_reg == '0 && char_in.ch == CHR_SPACE)
                        && cnt_reg < NOTE_CHARS)
                    begin
                        buf_we    = 1'b1;
                        cnt_after = cnt_reg + 1'b1;
                    end
                    cnt_next = cnt_after;
                    // A comma on an empty buffer emits nothing unless it ends the melody.
                    if ((char_in.ch == CHR_COMMA || char_in.end_of_melody)
                        && (cnt_after != '0 || char_in.end_of_melody))
                    begin
                        pos_next   = '0;
                        acc_next   = '0;
                        found_next = 1'b0;
                        if (cnt_after == '0)
                        begin
                            status_next = ST_ENDED;
                            dur_next    = '0;
                            tone_next   = '0;
                            dotted_next = 1'b0;
                            oct_next    = '0;
                            iv_next     = '0;
                            freq_next   = '0;
                            state_next  = S_FIN;
                        end
                        else
                            state_next = S_DUR;
                    end
                end
            end

            S_DUR:
            begin
                if (have_ch && is_digit)
                begin
                    acc_next   = acc_sat[DUR_W-1:0];
                    found_next = 1'b1;
                    pos_next   = pos_reg + 1'b1;
                end
                else if (!have_ch)
                begin
                    // Only digits in the note: everything but the status reads zero.
                    status_next = ST_EMPTY;
                    dur_next    = '0;
                    tone_next   = '0;
                    dotted_next = 1'b0;
                    oct_next    = '0;
                    iv_next     = '0;
                    freq_next   = '0;
                    state_next  = S_FIN;
                end
                else
                begin
                    dur_next    = found_reg ? acc_reg : def_dur_reg;
                    dotted_next = 1'b0;
                    acc_next    = '0;
                    found_next  = 1'b0;
                    state_next  = S_TONE;
                end
            end

            S_TONE:
            begin
                if (letter.valid)
                begin
                    tone_next     = letter.tone;
                    sharp_ok_next = letter.sharpable;
                    pos_next      = pos_reg + 1'b1;
                    state_next    = S_SHARP;
                end
                else
                begin
                    // An unknown letter keeps the previous tone and is not consumed.
                    tone_next  = last_tone_reg;
                    state_next = S_DOT;
                end
            end

            S_SHARP:
            begin
                if (have_ch && cur_ch == CHR_HASH)
                begin
                    if (sharp_ok_reg)
                        tone_next = tone_reg + 1'b1;
                    pos_next = pos_reg + 1'b1;
                end
                state_next = S_DOT;
            end

            S_DOT:
            begin
                if (have_ch && cur_ch == CHR_DOT)
                begin
                    dotted_next = 1'b1;
                    pos_next    = pos_reg + 1'b1;
                end
                state_next = S_OCT;
            end

            S_OCT:
            begin
                if (have_ch && is_digit)
                begin
                    acc_next   = acc_sat[DUR_W-1:0];
                    found_next = 1'b1;
                    pos_next   = pos_reg + 1'b1;
                end
                else
                begin
                    oct_next       = oct_final;
                    last_tone_next = tone_reg;
                    freq_next      = (tone_reg >= TONE_PAUSE) ? '0
                                                              : FREQ_W'(freq_rounded >> 8);
                    if (dur_reg == '0)
                    begin
                        status_next = ST_ZERO_DUR;
                        iv_next     = '0;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        status_next      = ST_OK;
                        div_req.start    = 1'b1;
                        div_req.dividend = MS_PER_MIN;
                        div_req.divisor  = tempo_eff;
                        state_next       = S_DIV1;
                    end
                end
            end

            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    // Whole-note time is four beats.
                    div_req.start    = 1'b1;
                    div_req.dividend = {div_rsp.quotient[DIV_W-3:0], 2'b00};
                    div_req.divisor  = {{(DVSR_W-DUR_W){1'b0}}, dur_reg};
                    state_next       = S_DIV2;
                end
            end

            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    iv_next = {1'b0, div_rsp.quotient}
                            + (dotted_reg ? {2'b00, div_rsp.quotient[DIV_W-1:1]} : '0);
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || note_out.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    cnt_next       = '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            last_tone_reg <= '0;
            out_valid_reg <= 1'b0;
            def_dur_reg   <= DEF_DUR_RST;
            def_oct_reg   <= DEF_OCT_RST;
            tempo_reg     <= TEMPO_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_tone_reg <= last_tone_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                case (wr_index)
                    CFG_DEF_DUR: def_dur_reg <= wr_data[DUR_W-1:0];
                    CFG_DEF_OCT: def_oct_reg <= wr_data[OCT_W-1:0];
                    CFG_TEMPO:   tempo_reg   <= wr_data[TEMPO_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            note_chars_reg[cnt_reg[IW-1:0]] <= char_in.ch;
        pos_reg      <= pos_next;
        acc_reg      <= acc_next;
        found_reg    <= found_next;
        dur_reg      <= dur_next;
        tone_reg     <= tone_next;
        sharp_ok_reg <= sharp_ok_next;
        dotted_reg   <= dotted_next;
        oct_reg      <= oct_next;
        iv_reg       <= iv_next;
        freq_reg     <= freq_next;
        status_reg   <= status_next;
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_tone_reg   <= tone_reg;
            out_oct_reg    <= oct_reg;
            out_dur_reg    <= dur_reg;
            out_dotted_reg <= dotted_reg;
            out_iv_reg     <= iv_reg;
            out_freq_reg   <= freq_reg;
        end
    end

    assign note_out.valid        = out_valid_reg;
    assign note_out.status       = out_status_reg;
    assign note_out.tone_index   = out_tone_reg;
    assign note_out.octave       = out_oct_reg;
    assign note_out.duration_div = out_dur_reg;
    assign note_out.dotted       = out_dotted_reg;
    assign note_out.interval_ms  = out_iv_reg;
    assign note_out.frequency_hz = out_freq_reg;

    `RTNP_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= NOTE_CHARS, "character count past buffer depth")
    `RTNP_ASSERT_IMP(a_zero_interval, out_valid_reg && out_status_reg == ST_ZERO_DUR,
        out_iv_reg == '0, "zero-duration note with nonzero interval")
    `RTNP_ASSERT_IMP(a_no_note_zero,
        out_valid_reg && (out_status_reg == ST_EMPTY || out_status_reg == ST_ENDED),
        out_iv_reg == '0 && out_freq_reg == '0 && out_dur_reg == '0,
        "note fields not cleared for a missing note")
    `RTNP_ASSERT_IMP(a_div_dur, state_reg == S_DIV1 || state_reg == S_DIV2, dur_reg != '0,
        "division entered with zero duration")

endmodule

/* sim/rtnp_note_compare.sv */
// Watches the character and note channels, predicts every note and compares it field by field.
module rtnp_note_compare
    import rtnp_pkg::*;
#(
    parameter int NOTE_LEN = NOTE_CHARS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rtnp_char_if                  char_mon,
    rtnp_note_if                  note_mon,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output int                    fail_count,
    output int                    pending,
    output int                    notes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 40;

    // Base pitch of each semitone in the lowest octave, in 1/256 Hz.
    localparam int unsigned PITCH_Q8 [12] = '{
        2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951
    };

    typedef struct packed {
        status_t            status;
        logic [TONE_W-1:0]  tone;
        logic [OCT_W-1:0]   octave;
        logic [DUR_W-1:0]   duration;
        logic               dotted;
        logic [IV_W-1:0]    interval;
        logic [FREQ_W-1:0]  freq;
    } note_t;

    note_t expected_notes [$];
    note_t want;

    logic [CH_W-1:0]    note_buf [NOTE_LEN];
    int unsigned        buf_len;
    logic [TONE_W-1:0]  prev_tone;
    logic [DUR_W-1:0]   cfg_dur;
    logic [OCT_W-1:0]   cfg_oct;
    logic [TEMPO_W-1:0] cfg_tempo;
    logic [CH_W-1:0]    in_ch;
    int                 mismatches;
    int                 checked;

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
        begin
            $display("%0t ns: note %0d: %s", $time, checked, what);
        end
        mismatches++;
    endtask

    function automatic int unsigned scan_number(inout int unsigned pos,
                                                input int unsigned limit,
                                                output bit found);
        int unsigned v;
        v = 0;
        found = 1'b0;
        while (pos < buf_len && note_buf[pos] >= CHR_0 && note_buf[pos] <= CHR_9)
        begin
            v = v * 10 + (note_buf[pos] - CHR_0);
            if (v > limit)
            begin
                v = limit;
            end
            found = 1'b1;
            pos++;
        end
        return v;
    endfunction

    // Parses the buffered characters into one note and remembers its tone.
    function automatic note_t decode_note();
        note_t n;
        int unsigned pos;
        int unsigned num;
        int unsigned dur;
        int unsigned oct;
        int unsigned tempo;
        int unsigned iv;
        int unsigned freq;
        int t;
        bit found;
        bit sharp;
        logic [TONE_W-1:0] tone;
        n = '0;
        pos = 0;
        tone = prev_tone;
        num = scan_number(pos, DUR_MAX, found);
        dur = found ? num : cfg_dur;
        if (pos >= buf_len)
        begin
            n.status = ST_EMPTY;
            return n;
        end
        sharp = (pos + 1 < buf_len) && (note_buf[pos + 1] == CHR_HASH);
        case (note_buf[pos])
            CHR_C:   t = sharp ? 1 : 0;
            CHR_D:   t = sharp ? 3 : 2;
            CHR_E:   t = 4;
            CHR_F:   t = sharp ? 6 : 5;
            CHR_G:   t = sharp ? 8 : 7;
            CHR_A:   t = sharp ? 10 : 9;
            CHR_B:   t = 11;
            CHR_P:   t = TONE_PAUSE;
            default: t = -1;
        endcase
        // An unknown letter is left in place and the previous tone carries over.
        if (t >= 0)
        begin
            tone = t[TONE_W-1:0];
            pos += sharp ? 2 : 1;
        end
        if (pos < buf_len && note_buf[pos] == CHR_DOT)
        begin
            n.dotted = 1'b1;
            pos++;
        end
        num = scan_number(pos, OCT_MAX, found);
        oct = found ? num : ((cfg_oct > OCT_MAX) ? OCT_MAX : cfg_oct);
        prev_tone = tone;

        n.tone = tone;
        n.octave = oct[OCT_W-1:0];
        n.duration = dur[DUR_W-1:0];
        if (dur == 0)
        begin
            n.status = ST_ZERO_DUR;
            n.interval = '0;
        end
        else
        begin
            tempo = (cfg_tempo == 0) ? 1 : cfg_tempo;
            iv = ((MS_PER_MIN / tempo) * 4) / dur;
            if (n.dotted)
            begin
                iv = iv / 2 + iv;
            end
            n.status = ST_OK;
            n.interval = iv[IV_W-1:0];
        end
        if (tone >= TONE_PAUSE)
        begin
            n.freq = '0;
        end
        else
        begin
            freq = ((PITCH_Q8[tone] << oct) + 128) >> 8;
            n.freq = freq[FREQ_W-1:0];
        end
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_notes.delete();
            buf_len = 0;
            prev_tone = '0;
            cfg_dur = DEF_DUR_RST;
            cfg_oct = DEF_OCT_RST;
            cfg_tempo = TEMPO_RST;
            mismatches = 0;
            checked = 0;
        end
        else
        begin
            if (note_mon.valid && note_mon.ready)
            begin
                if (expected_notes.size() == 0)
                begin
                    report_mismatch("note word arrived with nothing expected");
                end
                else
                begin
                    want = expected_notes.pop_front();
                    if (note_mon.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  note_mon.status, want.status.name()));
                    if (note_mon.tone_index !== want.tone)
                        report_mismatch($sformatf("tone_index %0d, expected %0d",
                                                  note_mon.tone_index, want.tone));
                    if (note_mon.octave !== want.octave)
                        report_mismatch($sformatf("octave %0d, expected %0d",
                                                  note_mon.octave, want.octave));
                    if (note_mon.duration_div !== want.duration)
                        report_mismatch($sformatf("duration_div %0d, expected %0d",
                                                  note_mon.duration_div, want.duration));
                    if (note_mon.dotted !== want.dotted)
                        report_mismatch($sformatf("dotted %0d, expected %0d",
                                                  note_mon.dotted, want.dotted));
                    if (note_mon.interval_ms !== want.interval)
                        report_mismatch($sformatf("interval_ms %0d, expected %0d",
                                                  note_mon.interval_ms, want.interval));
                    if (note_mon.frequency_hz !== want.freq)
                        report_mismatch($sformatf("frequency_hz %0d, expected %0d",
                                                  note_mon.frequency_hz, want.freq));
                end
                checked++;
            end

            if (char_mon.valid && char_mon.ready)
            begin
                in_ch = char_mon.ch;
                // Spaces ahead of a note are dropped, and so is anything past the buffer.
                if (in_ch != CHR_COMMA && !(buf_len == 0 && in_ch == CHR_SPACE)
                    && buf_len < NOTE_LEN)
                begin
                    note_buf[buf_len] = in_ch;
                    buf_len++;
                end
                if (in_ch == CHR_COMMA || char_mon.end_of_melody)
                begin
                    if (buf_len != 0)
                    begin
                        expected_notes.push_back(decode_note());
                    end
                    else if (char_mon.end_of_melody)
                    begin
                        want = '0;
                        want.status = ST_ENDED;
                        expected_notes.push_back(want);
                    end
                    buf_len = 0;
                end
            end

            if (wr_en)
            begin
                case (wr_index)
                    CFG_DEF_DUR: cfg_dur = wr_data[DUR_W-1:0];
                    CFG_DEF_OCT: cfg_oct = wr_data[OCT_W-1:0];
                    CFG_TEMPO:   cfg_tempo = wr_data[TEMPO_W-1:0];
                    default:     ;
                endcase
            end
        end
        fail_count <= mismatches;
        pending <= expected_notes.size();
        notes_checked <= checked;
    end

endmodule

/* sim/ringtone_note_parser_tb.sv */
// Top of the ringtone note parser testbench: clock, reset, character stimulus and verdict.
module ringtone_note_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtnp_pkg::*;

    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 120;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PHASE_CHARS   = 250;

    localparam logic [CH_W-1:0] TONE_LETTERS [8] = '{
        CHR_C, CHR_D, CHR_E, CHR_F, CHR_G, CHR_A, CHR_B, CHR_P
    };

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    bit calm;
    bit long_hold_req;
    int chars_sent;
    int fail_count;
    int pending;
    int notes_checked;

    rtnp_char_if char_ch ();
    rtnp_note_if note_ch ();

    ringtone_note_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_ch),
        .note_out (note_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    rtnp_note_compare note_compare (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_mon      (char_ch),
        .note_mon      (note_ch),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .notes_checked (notes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d notes still expected.", pending);
        $display("[ringtone_note_parser] ERROR");
        $finish;
    end

    // Note receiver: random stall bursts, plus one long hold so the parser backs up.
    initial
    begin
        int stall_left;
        bit hold_done;
        note_ch.ready = 1'b0;
        stall_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                note_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (long_hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                stall_left = LONG_HOLD - 1;
                note_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                note_ch.ready <= 1'b0;
            end
            else
            begin
                note_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_char(input logic [CH_W-1:0] c, input logic eom);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            char_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.ch <= c;
        char_ch.end_of_melody <= eom;
        do @(posedge clk); while (!char_ch.ready);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input bit eom_at_end);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], eom_at_end && (i == s.len() - 1));
        end
    endtask

    // Mostly well-formed notes with random fields; some noise and stray separators.
    task automatic send_random_note();
        string s;
        int r;
        bit eom_last;
        s = "";
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            repeat ($urandom_range(1, 6))
                send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 15) == 0));
            return;
        end
        if (r < 9)
        begin
            send_char($urandom_range(0, 1) ? CHR_COMMA : CHR_SPACE, 1'($urandom_range(0, 1)));
            return;
        end
        if ($urandom_range(0, 4) == 0)
            s = " ";
        r = $urandom_range(0, 9);
        if (r >= 4 && r < 8)
            s = $sformatf("%s%0d", s, 1 << $urandom_range(0, 5));
        else if (r == 8)
            s = $sformatf("%s%0d", s, $urandom_range(0, 999));
        else if (r == 9)
            s = {s, "0"};
        r = $urandom_range(0, 19);
        if (r < 15)
            s = $sformatf("%s%c", s, TONE_LETTERS[$urandom_range(0, 7)]);
        else if (r < 17)
            s = $sformatf("%s%c", s, 8'($urandom_range(8'h41, 8'h5A)));
        else if (r < 19)
            s = $sformatf("%s%c", s, 8'($urandom_range(1, 255)));
        if ($urandom_range(0, 2) == 0)
            s = {s, "#"};
        if ($urandom_range(0, 3) == 0)
            s = {s, "."};
        r = $urandom_range(0, 9);
        if (r < 6)
            s = $sformatf("%s%0d", s, $urandom_range(0, 9));
        else if (r == 6)
            s = $sformatf("%s%0d", s, $urandom_range(0, 99));
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 3))
                s = $sformatf("%s%c", s, 8'($urandom_range(8'h21, 8'h7E)));
        end
        eom_last = ($urandom_range(0, 11) == 0);
        r = $urandom_range(0, 11);
        // Either the last character carries the end marker, or a comma closes the note.
        if (!(r == 0 && s.len() > 0))
            s = {s, ","};
        else
            eom_last = 1'b1;
        send_text(s, eom_last);
    endtask

    // Lets every expected note come out and the parser go quiet before a register write.
    task automatic settle();
        int waited;
        char_ch.valid <= 1'b0;
        waited = 0;
        repeat (2) @(posedge clk);
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [DUR_W-1:0] dur, input logic [OCT_W-1:0] oct,
                              input logic [TEMPO_W-1:0] tempo);
        wr_en <= 1'b1;
        wr_index <= CFG_DEF_DUR;
        wr_data <= {2'($urandom), dur};
        @(posedge clk);
        wr_index <= CFG_DEF_OCT;
        wr_data <= {6'($urandom), oct};
        @(posedge clk);
        wr_index <= CFG_TEMPO;
        wr_data <= tempo;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    initial
    begin
        int target;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        char_ch.valid = 1'b0;
        char_ch.ch = '0;
        char_ch.end_of_melody = 1'b0;
        calm = 1'b0;
        long_hold_req = 1'b0;
        chars_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed notes under the reset settings.
        send_text(" 8c#.5,", 1'b0);
        send_text("999p#.7,", 1'b0);
        send_text("0b#99,", 1'b0);
        send_text("Dg,", 1'b0);
        send_text("12,", 1'b0);
        send_text("a", 1'b1);
        send_text(",", 1'b1);

        target = chars_sent;
        for (int phase = 0; phase < 6; phase++)
        begin
            settle();
            case (phase)
                0:       set_config(8'd1, 4'd0, 10'd1);
                1:       set_config(8'd255, 4'd9, 10'd900);
                2:       set_config(8'd0, 4'd15, 10'd0);
                3:       set_config(8'd255, 4'd15, 10'd1023);
                default: set_config(8'($urandom_range(1, 255)), 4'($urandom_range(0, 9)),
                                    10'($urandom_range(1, 900)));
            endcase
            if (phase == 2)
                long_hold_req = 1'b1;
            if (phase == 5)
                calm = 1'b1;
            target += PHASE_CHARS;
            while (chars_sent < target)
                send_random_note();
        end
        settle();

        $display("Sent %0d characters and checked %0d notes under 7 register settings,",
                 chars_sent, notes_checked);
        $display("including zero and out-of-range settings and one long output stall.");
        if (pending != 0)
            $display("%0d notes were expected but never came out.", pending);
        if (fail_count == 0 && pending == 0)
        begin
            $display("[ringtone_note_parser] OK");
        end
        else
        begin
            $display("[ringtone_note_parser] ERROR");
        end
        $finish;
    end

endmodule

/* ringtone_note_parser.f */
+incdir+rtl
rtl/rtnp_pkg.sv
rtl/rtnp_ifs.sv
rtl/rtnp_divider.sv
rtl/ringtone_note_parser.sv
sim/rtnp_note_compare.sv
sim/ringtone_note_parser_tb.sv
